@@ rtl/lpc_pkg.sv @@
// package for the lattice lpc synthesis filter
// holds lattice order, fixed-point limits and the command record passed front to back
// no dependencies
package lpc_pkg;

    // lattice order and coefficient store
    localparam int ORDER       = 16;
    localparam int COEF_DEPTH  = 16;
    localparam int COEF_IDX_W  = 4;
    localparam int STAGE_W     = (ORDER > 1) ? $clog2(ORDER) : 1;

    // command queue between front and back, depth is a power of two
    localparam int QUEUE_DEPTH = 2;

    // stability and output limits, state has 8 fraction bits
    localparam logic signed [31:0] STAGE_LIMIT = 32'sd8388352;
    localparam logic signed [23:0] OUT_LIMIT   = 24'sd32766;

    // request kinds
    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    // classified request: data is the coefficient for a load, the residual for a sample
    typedef struct packed {
        t_op                     op;
        logic [COEF_IDX_W-1:0]   index;
        logic signed [15:0]      data;
    } t_cmd;

endpackage

@@ rtl/lpc_cmd_queue.sv @@
// front of the lattice filter: accepts requests, classifies them and queues them
// depends on lpc_pkg (t_cmd, t_op, QUEUE_DEPTH)
module lpc_cmd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [3:0]         i_coef_index,
    input  logic signed [15:0] i_coef_value,
    input  logic signed [15:0] i_residual_sample,
    output lpc_pkg::t_cmd      o_cmd,
    output logic               o_cmd_valid,
    input  logic               i_cmd_pop
);
    import lpc_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    t_cmd              n_cmd;
    logic              push;
    logic              pop;

    // classify the incoming request
    always_comb begin
        n_cmd.op    = i_operation ? OP_SAMPLE : OP_LOAD;
        n_cmd.index = i_coef_index;
        n_cmd.data  = i_operation ? i_residual_sample : i_coef_value;
    end

    assign o_in_ready  = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = i_cmd_pop && o_cmd_valid;

    // queue storage and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_slot[r_wr_ptr] <= n_cmd;
                r_wr_ptr         <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/lpc_lattice.sv @@
// back of the lattice filter: coefficient store, lattice memory and stage sequencer
// depends on lpc_pkg (t_cmd, ORDER, limits)
module lpc_lattice (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpc_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_valid,
    output logic               o_cmd_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_output_sample,
    output logic               o_unstable
);
    import lpc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EUPD,
        S_MUL2,
        S_FINISH
    } t_state;

    localparam logic [STAGE_W-1:0] TOP_STAGE = STAGE_W'(ORDER - 1);

    t_state              r_state;
    logic signed [15:0]  r_coef [COEF_DEPTH];
    logic signed [31:0]  r_mem [ORDER];
    logic [STAGE_W-1:0]  r_stage;
    logic signed [31:0]  r_e;
    logic signed [15:0]  r_k;
    logic signed [31:0]  r_s;
    logic signed [15:0]  r_k_nx;
    logic signed [31:0]  r_s_nx;
    logic signed [47:0]  r_p1;
    logic signed [47:0]  r_p2;
    logic                r_wr_pending;
    logic [STAGE_W-1:0]  r_wr_idx;
    logic signed [31:0]  r_wr_s;
    logic                r_out_valid;
    logic signed [15:0]  r_out_sample;
    logic                r_out_unstable;

    logic [STAGE_W-1:0]  rd_sel;
    logic signed [15:0]  k_sel;
    logic signed [31:0]  s_sel;
    logic signed [47:0]  n_p1;
    logic signed [47:0]  n_p2;
    logic signed [31:0]  n_e;
    logic signed [31:0]  n_wr;
    logic signed [23:0]  y_int;
    logic signed [15:0]  y_sat;
    logic                blow_up;
    logic                out_free;

    // product plus half an lsb, then floor shift by 15
    function automatic logic signed [32:0] rnd15(input logic signed [47:0] p);
        logic signed [47:0] t;
        t = p + 48'sd16384;
        return t[47:15];
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // coefficient for a stage, zero past the store
    function automatic logic signed [15:0] coef_at(input logic [5:0] idx,
                                                   input logic signed [15:0] bank [COEF_DEPTH]);
        if (idx < 6'(COEF_DEPTH)) begin
            return bank[idx[COEF_IDX_W-1:0]];
        end
        return 16'sd0;
    endfunction

    // look-ahead read of the next stage coefficient and state
    assign rd_sel = (r_state == S_IDLE) ? TOP_STAGE : (r_stage - 1'b1);
    assign k_sel  = coef_at(6'(rd_sel), r_coef);
    assign s_sel  = r_mem[rd_sel];
    assign n_p1   = 48'(k_sel) * 48'(s_sel);

    // excitation update, second product and delayed state update
    assign n_e  = sat32(34'(r_e) - 34'(rnd15(r_p1)));
    assign n_p2 = 48'(r_k) * 48'(r_e);
    assign n_wr = sat32(34'(r_wr_s) + 34'(rnd15(r_p2)));

    // output conversion: drop the fraction toward zero, then clamp
    always_comb begin
        y_int = r_e[31:8] + 24'((r_e[31] && (r_e[7:0] != 8'h00)) ? 1 : 0);
        if (y_int > OUT_LIMIT) begin
            y_sat = 16'(OUT_LIMIT);
        end else if (y_int < -OUT_LIMIT) begin
            y_sat = 16'(-OUT_LIMIT);
        end else begin
            y_sat = y_int[15:0];
        end
    end

    // the pending write in the final step is s[1]
    assign blow_up  = r_wr_pending && ((n_wr > STAGE_LIMIT) || (n_wr < -STAGE_LIMIT));
    assign out_free = !r_out_valid || i_out_ready;

    assign o_cmd_pop       = (r_state == S_IDLE) && i_cmd_valid;
    assign o_out_valid     = r_out_valid;
    assign o_output_sample = r_out_sample;
    assign o_unstable      = r_out_unstable;

    // sequencer: each stage runs an excitation-update step and a second-multiply step, state writes trail by one stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_coef       <= '{default: '0};
            r_mem        <= '{default: '0};
            r_stage      <= '0;
            r_wr_pending <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // the finish step refills the output register itself
            if (r_out_valid && i_out_ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.op == OP_LOAD) begin
                            r_coef[i_cmd.index] <= i_cmd.data;
                        end else begin
                            r_e          <= {{8{i_cmd.data[15]}}, i_cmd.data, 8'h00};
                            r_p1         <= n_p1;
                            r_k          <= k_sel;
                            r_s          <= s_sel;
                            r_stage      <= TOP_STAGE;
                            r_wr_pending <= 1'b0;
                            r_state      <= S_EUPD;
                        end
                    end
                end
                S_EUPD: begin
                    r_e <= n_e;
                    if (r_wr_pending) begin
                        r_mem[r_wr_idx] <= n_wr;
                    end
                    r_wr_pending <= 1'b0;
                    if (r_stage != '0) begin
                        r_p1   <= n_p1;
                        r_k_nx <= k_sel;
                        r_s_nx <= s_sel;
                    end
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    if (r_stage != TOP_STAGE) begin
                        r_p2         <= n_p2;
                        r_wr_pending <= 1'b1;
                        r_wr_idx     <= r_stage + 1'b1;
                        r_wr_s       <= r_s;
                    end
                    if (r_stage == '0) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_stage <= r_stage - 1'b1;
                        r_k     <= r_k_nx;
                        r_s     <= r_s_nx;
                        r_state <= S_EUPD;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        if (blow_up) begin
                            r_mem          <= '{default: '0};
                            r_out_sample   <= 16'sd0;
                            r_out_unstable <= 1'b1;
                        end else begin
                            if (r_wr_pending) begin
                                r_mem[r_wr_idx] <= n_wr;
                            end
                            r_mem[0]       <= r_e;
                            r_out_sample   <= y_sat;
                            r_out_unstable <= 1'b0;
                        end
                        r_wr_pending <= 1'b0;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/lattice_lpc_synthesis_filter.sv @@
// lattice lpc synthesis filter, top level: request queue feeding the lattice sequencer
// a load request is popped by the idle sequencer and gives no result; a sample request
// walks every stage through the lattice multipliers, and the sequencer takes no new
// request from the queue until that sample's result is registered
// synchronous active-low reset clears coefficients, lattice memory, queue and output
// depends on lpc_pkg, lpc_cmd_queue, lpc_lattice
module lattice_lpc_synthesis_filter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [3:0]         i_coef_index,
    input  logic signed [15:0] i_coef_value,
    input  logic signed [15:0] i_residual_sample,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_output_sample,
    output logic               o_unstable
);
    import lpc_pkg::*;

    t_cmd q_cmd;
    logic q_valid;
    logic q_pop;

    // front: accept and classify requests
    lpc_cmd_queue u_queue (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_operation       (i_operation),
        .i_coef_index      (i_coef_index),
        .i_coef_value      (i_coef_value),
        .i_residual_sample (i_residual_sample),
        .o_cmd             (q_cmd),
        .o_cmd_valid       (q_valid),
        .i_cmd_pop         (q_pop)
    );

    // back: run the lattice
    lpc_lattice u_lattice (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (q_cmd),
        .i_cmd_valid     (q_valid),
        .o_cmd_pop       (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_output_sample (o_output_sample),
        .o_unstable      (o_unstable)
    );

    // an unstable result always carries a zero sample
    a_unstable_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_unstable) |-> (o_output_sample == 16'sd0))
        else $error("unstable result with nonzero sample");

    // results stay inside the output clamp
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_output_sample <= 16'sd32766) && (o_output_sample >= -16'sd32766)))
        else $error("output sample outside clamp range");

    // a full queue is never seen as empty by the back
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> q_valid)
        else $error("queue full but not valid");

    // the back only pops what the queue offers
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule
